// ----- rtl/first_fit_two_resource_placer_assert.svh -----
// ----------------------------------------------------------------------------
// first_fit_two_resource_placer_assert.svh
// Assertion macros for the first-fit placer. They expand to nothing when the
// SYNTHESIS macro is set.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_TWO_RESOURCE_PLACER_ASSERT_SVH
`define FIRST_FIT_TWO_RESOURCE_PLACER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define FFP_ASSERT_IMM(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FFP_ASSERT_IMM(lbl, clk, rstn, ante, cons, msg)
`define FFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/ffp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, constants and helper functions of the first-fit placer.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int SLICE_W   = 4;
    localparam int TABLE_W   = 20;
    localparam int PROFILE_W = 3;
    localparam int COUNT_W   = 4;
    localparam int OUT_BIN_W = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [TABLE_W-1:0] COMPUTE_TABLE_RST = 20'd475937;
    localparam logic [TABLE_W-1:0] MEMORY_TABLE_RST  = 20'd541729;
    localparam logic [SLICE_W-1:0] COMPUTE_CAP_RST   = 4'd7;
    localparam logic [SLICE_W-1:0] MEMORY_CAP_RST    = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic [1:0] {
        REG_COMPUTE_TABLE = 2'd0,
        REG_MEMORY_TABLE  = 2'd1,
        REG_COMPUTE_CAP   = 2'd2,
        REG_MEMORY_CAP    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_RDCNT,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TABLE_W-1:0] compute_table;
        logic [TABLE_W-1:0] memory_table;
        logic [SLICE_W-1:0] compute_cap;
        logic [SLICE_W-1:0] memory_cap;
    } t_cfg;

    typedef struct packed {
        logic [SLICE_W-1:0] compute;
        logic [SLICE_W-1:0] memory;
    } t_bin_entry;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic scan;
        logic take_hit;
        logic take_new;
        logic set_noroom;
        logic rd_cnt;
        logic write;
        logic push;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic bad_profile;
        logic fit;
        logic exhausted;
        logic new_ok;
        logic out_free;
    } t_sts;

    function automatic logic [SLICE_W-1:0] nibble_of(input logic [TABLE_W-1:0] tbl,
                                                     input logic [PROFILE_W-1:0] p);
        logic [SLICE_W-1:0] nib;
        case (p)
            3'd0:    nib = tbl[3:0];
            3'd1:    nib = tbl[7:4];
            3'd2:    nib = tbl[11:8];
            3'd3:    nib = tbl[15:12];
            3'd4:    nib = tbl[19:16];
            default: nib = '0;
        endcase
        return nib;
    endfunction

endpackage

// ----- rtl/first_fit_two_resource_placer.sv -----
`timescale 1ns / 1ps
// After its transfer, a request passes through lookup, first-fit scan, count read and write-back
// before its result is loaded into the output register; a refused request skips the later steps.
// The next request is taken the cycle after the result is loaded; the bin memory scan
// makes one read per cycle over the open bins.
// Synchronous active-low reset clears the open-bin count, sequencer and output valid, and
// restores the configuration defaults; bin memories are written as each bin is opened.
// ----------------------------------------------------------------------------
// first_fit_two_resource_placer
// Two-resource first-fit placer: places each profile request in the first open
// bin with enough compute and memory slices, opens a new bin, or reports no room.
// ----------------------------------------------------------------------------
`include "first_fit_two_resource_placer_assert.svh"

module first_fit_two_resource_placer #(
    parameter int NUM_BINS     = 16,
    parameter int NUM_PROFILES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ffp_pkg::PROFILE_W-1:0]       i_profile,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ffp_pkg::OUT_BIN_W-1:0]       o_bin_index,
    output logic                                o_opened_new,
    output logic                                o_no_room,
    output logic [ffp_pkg::SLICE_W-1:0]         o_compute_left,
    output logic [ffp_pkg::SLICE_W-1:0]         o_memory_left,
    output logic [ffp_pkg::COUNT_W-1:0]         o_profile_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffp_pkg::PADDR_W-1:0]         paddr,
    input  logic [ffp_pkg::PDATA_W-1:0]         pwdata,
    output logic [ffp_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    ffp_pkg::t_cfg w_cfg;
    ffp_pkg::t_cmd w_cmd;
    ffp_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign o_in_stall = !w_in_ready;

    ffp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ffp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    ffp_dp #(
        .NUM_BINS     (NUM_BINS),
        .NUM_PROFILES (NUM_PROFILES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_profile       (i_profile),
        .i_out_stall     (i_out_stall),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_bin_index     (o_bin_index),
        .o_opened_new    (o_opened_new),
        .o_no_room       (o_no_room),
        .o_compute_left  (o_compute_left),
        .o_memory_left   (o_memory_left),
        .o_profile_count (o_profile_count)
    );

    // One request at a time: a transfer in closes the input until the result is loaded.
    `FFP_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input accepted while a request is in progress")

    // A refused request reports nothing but the no-room flag.
    `FFP_ASSERT_IMM(a_noroom_zero, i_clk, i_rst_n, o_out_valid && o_no_room, o_bin_index == '0 && !o_opened_new && o_compute_left == '0 && o_memory_left == '0 && o_profile_count == '0, "no-room result carries nonzero fields")

    // A freshly opened bin holds exactly the one instance just placed.
    `FFP_ASSERT_IMM(a_new_bin_count, i_clk, i_rst_n, o_out_valid && o_opened_new, !o_no_room && o_profile_count == 4'd1, "new bin result has wrong count or no-room flag")

endmodule

// ----- rtl/ffp_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_regs
// APB configuration registers: demand tables and fresh-bin capacities.
// ----------------------------------------------------------------------------
module ffp_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffp_pkg::PADDR_W-1:0]     paddr,
    input  logic [ffp_pkg::PDATA_W-1:0]     pwdata,
    output logic [ffp_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output ffp_pkg::t_cfg                   o_cfg
);

    ffp_pkg::t_cfg    r_cfg;
    ffp_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = ffp_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compute_table <= ffp_pkg::COMPUTE_TABLE_RST;
            r_cfg.memory_table  <= ffp_pkg::MEMORY_TABLE_RST;
            r_cfg.compute_cap   <= ffp_pkg::COMPUTE_CAP_RST;
            r_cfg.memory_cap    <= ffp_pkg::MEMORY_CAP_RST;
        end else if (w_wr) begin
            case (w_idx)
                ffp_pkg::REG_COMPUTE_TABLE: begin
                    r_cfg.compute_table <= pwdata[ffp_pkg::TABLE_W-1:0];
                end
                ffp_pkg::REG_MEMORY_TABLE: begin
                    r_cfg.memory_table <= pwdata[ffp_pkg::TABLE_W-1:0];
                end
                ffp_pkg::REG_COMPUTE_CAP: begin
                    r_cfg.compute_cap <= pwdata[ffp_pkg::SLICE_W-1:0];
                end
                ffp_pkg::REG_MEMORY_CAP: begin
                    r_cfg.memory_cap <= pwdata[ffp_pkg::SLICE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ffp_pkg::REG_COMPUTE_TABLE: prdata = 32'(r_cfg.compute_table);
            ffp_pkg::REG_MEMORY_TABLE:  prdata = 32'(r_cfg.memory_table);
            ffp_pkg::REG_COMPUTE_CAP:   prdata = 32'(r_cfg.compute_cap);
            ffp_pkg::REG_MEMORY_CAP:    prdata = 32'(r_cfg.memory_cap);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/ffp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_ctrl
// Sequencer of the placer: lookup, first-fit scan, count read, write-back
// and result hand-off.
// ----------------------------------------------------------------------------
module ffp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ffp_pkg::t_sts   i_sts,
    output ffp_pkg::t_cmd   o_cmd,
    output logic            o_in_ready
);

    ffp_pkg::t_state r_state;
    ffp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffp_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ffp_pkg::S_LOOKUP;
            end
            ffp_pkg::S_LOOKUP: begin
                n_state = i_sts.bad_profile ? ffp_pkg::S_DONE : ffp_pkg::S_SCAN;
            end
            ffp_pkg::S_SCAN: begin
                if (i_sts.fit) begin
                    n_state = ffp_pkg::S_RDCNT;
                end else if (i_sts.exhausted) begin
                    n_state = i_sts.new_ok ? ffp_pkg::S_RDCNT : ffp_pkg::S_DONE;
                end
            end
            ffp_pkg::S_RDCNT: n_state = ffp_pkg::S_WRITE;
            ffp_pkg::S_WRITE: n_state = ffp_pkg::S_DONE;
            ffp_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = ffp_pkg::S_IDLE;
            end
            default: n_state = ffp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ffp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ffp_pkg::S_LOOKUP: begin
                o_cmd.lookup     = 1'b1;
                o_cmd.set_noroom = i_sts.bad_profile;
            end
            ffp_pkg::S_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.take_hit   = i_sts.fit;
                o_cmd.take_new   = !i_sts.fit && i_sts.exhausted && i_sts.new_ok;
                o_cmd.set_noroom = !i_sts.fit && i_sts.exhausted && !i_sts.new_ok;
            end
            ffp_pkg::S_RDCNT: o_cmd.rd_cnt = 1'b1;
            ffp_pkg::S_WRITE: o_cmd.write  = 1'b1;
            ffp_pkg::S_DONE:  o_cmd.push   = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/ffp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_dp
// Datapath of the placer: demand lookup, bin memory scan, instance count
// memory, open-bin counter and the output register.
// ----------------------------------------------------------------------------
module ffp_dp #(
    parameter int NUM_BINS     = 16,
    parameter int NUM_PROFILES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffp_pkg::t_cmd                       i_cmd,
    input  ffp_pkg::t_cfg                       i_cfg,
    input  logic [ffp_pkg::PROFILE_W-1:0]       i_profile,
    input  logic                                i_out_stall,
    output ffp_pkg::t_sts                       o_sts,
    output logic                                o_out_valid,
    output logic [ffp_pkg::OUT_BIN_W-1:0]       o_bin_index,
    output logic                                o_opened_new,
    output logic                                o_no_room,
    output logic [ffp_pkg::SLICE_W-1:0]         o_compute_left,
    output logic [ffp_pkg::SLICE_W-1:0]         o_memory_left,
    output logic [ffp_pkg::COUNT_W-1:0]         o_profile_count
);

    localparam int OPEN_W = $clog2(NUM_BINS + 1);
    localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ROW_W  = ffp_pkg::COUNT_W * NUM_PROFILES;
    localparam int SW     = ffp_pkg::SLICE_W;
    localparam int CW     = ffp_pkg::COUNT_W;

    // Bin remaining capacity and per-bin instance count rows.
    ffp_pkg::t_bin_entry   bin_mem [NUM_BINS];
    logic [ROW_W-1:0]      cnt_mem [NUM_BINS];

    logic [ffp_pkg::PROFILE_W-1:0] r_profile;
    logic [SW-1:0]                 r_need_c;
    logic [SW-1:0]                 r_need_m;
    logic [OPEN_W-1:0]             r_open;
    logic [OPEN_W-1:0]             r_issue;
    logic                          r_rd_vld;
    logic [BIN_AW-1:0]             r_rd_bin;
    ffp_pkg::t_bin_entry           r_rd_data;
    logic [BIN_AW-1:0]             r_bin;
    logic [SW-1:0]                 r_c;
    logic [SW-1:0]                 r_m;
    logic                          r_fresh;
    logic                          r_noroom;
    logic [ROW_W-1:0]              r_cnt_row;
    logic [CW-1:0]                 r_cnt;

    logic                          r_out_valid;
    logic [ffp_pkg::OUT_BIN_W-1:0] r_out_bin;
    logic                          r_out_new;
    logic                          r_out_noroom;
    logic [SW-1:0]                 r_out_c;
    logic [SW-1:0]                 r_out_m;
    logic [CW-1:0]                 r_out_cnt;

    logic                          w_issue;
    logic [CW-1:0]                 w_old_cnt;
    logic [CW-1:0]                 w_new_cnt;
    logic [ROW_W-1:0]              w_new_row;
    logic [BIN_AW+ffp_pkg::OUT_BIN_W-1:0] w_bin_ext;

    assign w_issue = i_cmd.scan && (r_issue < r_open);

    assign o_sts.bad_profile = r_profile >= ffp_pkg::PROFILE_W'(NUM_PROFILES);
    assign o_sts.fit         = r_rd_vld && (r_rd_data.compute >= r_need_c) &&
                               (r_rd_data.memory >= r_need_m);
    assign o_sts.exhausted   = !r_rd_vld && (r_issue >= r_open);
    assign o_sts.new_ok      = (r_open < OPEN_W'(NUM_BINS)) &&
                               (r_need_c <= i_cfg.compute_cap) &&
                               (r_need_m <= i_cfg.memory_cap);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    // New count row: a fresh bin starts with every count at zero.
    always_comb begin
        w_old_cnt = '0;
        for (int g = 0; g < NUM_PROFILES; g++) begin
            if (3'(g) == r_profile && !r_fresh) w_old_cnt = r_cnt_row[g*CW +: CW];
        end
        w_new_cnt = (w_old_cnt == ffp_pkg::COUNT_MAX) ? w_old_cnt : w_old_cnt + CW'(1);
        for (int g = 0; g < NUM_PROFILES; g++) begin
            if (3'(g) == r_profile) begin
                w_new_row[g*CW +: CW] = w_new_cnt;
            end else begin
                w_new_row[g*CW +: CW] = r_fresh ? '0 : r_cnt_row[g*CW +: CW];
            end
        end
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (w_issue) r_rd_data <= bin_mem[r_issue[BIN_AW-1:0]];
        if (i_cmd.rd_cnt) r_cnt_row <= cnt_mem[r_bin];
        if (i_cmd.write) begin
            bin_mem[r_bin] <= '{compute: r_c - r_need_c, memory: r_m - r_need_m};
            cnt_mem[r_bin] <= w_new_row;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= '0;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.lookup) begin
                r_issue  <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= w_issue;
                if (w_issue) r_issue <= r_issue + OPEN_W'(1);
            end
            if (i_cmd.write && r_fresh) r_open <= r_open + OPEN_W'(1);
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_profile <= i_profile;
            r_noroom  <= 1'b0;
        end
        if (i_cmd.lookup) begin
            r_need_c <= ffp_pkg::nibble_of(i_cfg.compute_table, r_profile);
            r_need_m <= ffp_pkg::nibble_of(i_cfg.memory_table, r_profile);
        end
        if (w_issue) r_rd_bin <= r_issue[BIN_AW-1:0];
        if (i_cmd.set_noroom) r_noroom <= 1'b1;
        if (i_cmd.take_hit) begin
            r_bin   <= r_rd_bin;
            r_c     <= r_rd_data.compute;
            r_m     <= r_rd_data.memory;
            r_fresh <= 1'b0;
        end
        if (i_cmd.take_new) begin
            r_bin   <= r_open[BIN_AW-1:0];
            r_c     <= i_cfg.compute_cap;
            r_m     <= i_cfg.memory_cap;
            r_fresh <= 1'b1;
        end
        if (i_cmd.write) begin
            r_c   <= r_c - r_need_c;
            r_m   <= r_m - r_need_m;
            r_cnt <= w_new_cnt;
        end
    end

    assign w_bin_ext = {{ffp_pkg::OUT_BIN_W{1'b0}}, r_bin};

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (r_noroom) begin
                r_out_bin    <= '0;
                r_out_new    <= 1'b0;
                r_out_noroom <= 1'b1;
                r_out_c      <= '0;
                r_out_m      <= '0;
                r_out_cnt    <= '0;
            end else begin
                r_out_bin    <= w_bin_ext[ffp_pkg::OUT_BIN_W-1:0];
                r_out_new    <= r_fresh;
                r_out_noroom <= 1'b0;
                r_out_c      <= r_c;
                r_out_m      <= r_m;
                r_out_cnt    <= r_cnt;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bin_index     = r_out_bin;
    assign o_opened_new    = r_out_new;
    assign o_no_room       = r_out_noroom;
    assign o_compute_left  = r_out_c;
    assign o_memory_left   = r_out_m;
    assign o_profile_count = r_out_cnt;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit two-resource placer. Profile requests
// go in through the valid/stall port. A tracker class keeps its own copy of
// the bins and the demand tables, predicts each placement, and compares every
// result transfer field by field. Tables and capacities are rewritten over
// APB between phases while the block is idle. Both sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
    import ffp_pkg::*;

    localparam int NUM_BINS       = 16;
    localparam int NUM_PROFILES   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = NUM_BINS + 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [OUT_BIN_W-1:0] bin;
        logic                 opened_new;
        logic                 no_room;
        logic [SLICE_W-1:0]   compute_left;
        logic [SLICE_W-1:0]   memory_left;
        logic [COUNT_W-1:0]   count;
    } t_placement;

    // Tracks bin occupancy and predicts where each request lands.
    class bin_placement_tracker;
        logic [TABLE_W-1:0] compute_table;
        logic [TABLE_W-1:0] memory_table;
        logic [SLICE_W-1:0] compute_cap;
        logic [SLICE_W-1:0] memory_cap;
        int                 open_bins;
        logic [SLICE_W-1:0] compute_free [NUM_BINS];
        logic [SLICE_W-1:0] memory_free [NUM_BINS];
        logic [COUNT_W-1:0] instances [NUM_BINS][NUM_PROFILES];
        t_placement         awaited [$];
        int                 errors;

        function new();
            compute_table = COMPUTE_TABLE_RST;
            memory_table  = MEMORY_TABLE_RST;
            compute_cap   = COMPUTE_CAP_RST;
            memory_cap    = MEMORY_CAP_RST;
            open_bins     = 0;
            errors        = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_COMPUTE_TABLE: compute_table = value[TABLE_W-1:0];
                REG_MEMORY_TABLE:  memory_table  = value[TABLE_W-1:0];
                REG_COMPUTE_CAP:   compute_cap   = value[SLICE_W-1:0];
                REG_MEMORY_CAP:    memory_cap    = value[SLICE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [PROFILE_W-1:0] prof);
            t_placement         res;
            logic [SLICE_W-1:0] need_c;
            logic [SLICE_W-1:0] need_m;
            int                 bin;
            int                 k;
            bit                 placed;
            bit                 fresh;
            res = '0;
            res.no_room = 1'b1;
            placed = 1'b0;
            fresh = 1'b0;
            bin = 0;
            if (int'(prof) < NUM_PROFILES) begin
                need_c = compute_table[4*int'(prof) +: 4];
                need_m = memory_table[4*int'(prof) +: 4];
                for (k = 0; k < open_bins; k++) begin
                    if (!placed && compute_free[k] >= need_c && memory_free[k] >= need_m) begin
                        bin = k;
                        placed = 1'b1;
                    end
                end
                // A fresh bin only helps if it can hold the whole demand.
                if (!placed && open_bins < NUM_BINS && need_c <= compute_cap &&
                    need_m <= memory_cap) begin
                    bin = open_bins;
                    open_bins++;
                    compute_free[bin] = compute_cap;
                    memory_free[bin] = memory_cap;
                    for (k = 0; k < NUM_PROFILES; k++) begin
                        instances[bin][k] = '0;
                    end
                    placed = 1'b1;
                    fresh = 1'b1;
                end
                if (placed) begin
                    compute_free[bin] = compute_free[bin] - need_c;
                    memory_free[bin] = memory_free[bin] - need_m;
                    if (instances[bin][prof] != COUNT_MAX) begin
                        instances[bin][prof] = instances[bin][prof] + 1'b1;
                    end
                    res.bin = bin[OUT_BIN_W-1:0];
                    res.opened_new = fresh;
                    res.no_room = 1'b0;
                    res.compute_left = compute_free[bin];
                    res.memory_left = memory_free[bin];
                    res.count = instances[bin][prof];
                end
            end
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(t_placement got);
            t_placement want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result transfer with nothing outstanding: bin %0d", $realtime,
                             got.bin);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.bin !== want.bin || got.opened_new !== want.opened_new ||
                got.no_room !== want.no_room || got.compute_left !== want.compute_left ||
                got.memory_left !== want.memory_left || got.count !== want.count) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: placement mismatch", $realtime);
                    $display("  expected bin %0d new %0b no_room %0b compute %0d memory %0d count %0d",
                             want.bin, want.opened_new, want.no_room, want.compute_left,
                             want.memory_left, want.count);
                    $display("  actual   bin %0d new %0b no_room %0b compute %0d memory %0d count %0d",
                             got.bin, got.opened_new, got.no_room, got.compute_left,
                             got.memory_left, got.count);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PROFILE_W-1:0] i_profile = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUT_BIN_W-1:0] o_bin_index;
    logic                 o_opened_new;
    logic                 o_no_room;
    logic [SLICE_W-1:0]   o_compute_left;
    logic [SLICE_W-1:0]   o_memory_left;
    logic [COUNT_W-1:0]   o_profile_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bin_placement_tracker placements;
    bit                   steady_flow = 1'b0;
    int                   idle_cycles = 0;

    first_fit_two_resource_placer #(
        .NUM_BINS    (NUM_BINS),
        .NUM_PROFILES(NUM_PROFILES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_profile      (i_profile),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_index    (o_bin_index),
        .o_opened_new   (o_opened_new),
        .o_no_room      (o_no_room),
        .o_compute_left (o_compute_left),
        .o_memory_left  (o_memory_left),
        .o_profile_count(o_profile_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_request(input logic [PROFILE_W-1:0] prof);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_profile <= prof;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        placements.note_request(prof);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        placements.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [PDATA_W-1:0] compute_tbl,
                              input logic [PDATA_W-1:0] memory_tbl,
                              input logic [PDATA_W-1:0] compute_cap,
                              input logic [PDATA_W-1:0] memory_cap);
        apb_write(REG_COMPUTE_TABLE, compute_tbl);
        apb_write(REG_MEMORY_TABLE, memory_tbl);
        apb_write(REG_COMPUTE_CAP, compute_cap);
        apb_write(REG_MEMORY_CAP, memory_cap);
    endtask

    // Waits until every request has been answered and the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (placements.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Demand tables lean toward small nibbles so later requests still fit
    // into the space left in bins that are already open.
    function automatic logic [PDATA_W-1:0] draw_demand_table();
        logic [PDATA_W-1:0] tbl;
        int                 p;
        tbl = '0;
        for (p = 0; p < NUM_PROFILES; p++) begin
            case ($urandom_range(0, 3))
                0:       tbl[4*p +: 4] = 4'd0;
                3:       tbl[4*p +: 4] = 4'($urandom_range(0, 15));
                default: tbl[4*p +: 4] = 4'($urandom_range(1, 3));
            endcase
        end
        return tbl;
    endfunction

    task automatic send_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(PROFILE_W'($urandom_range(NUM_PROFILES, 7)));
            end else begin
                send_request(PROFILE_W'($urandom_range(0, NUM_PROFILES - 1)));
            end
        end
    endtask

    initial begin
        t_placement got;
        int         hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = steady_flow ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(negedge i_clk); while (!o_out_valid);
            got.bin = o_bin_index;
            got.opened_new = o_opened_new;
            got.no_room = o_no_room;
            got.compute_left = o_compute_left;
            got.memory_left = o_memory_left;
            got.count = o_profile_count;
            @(posedge i_clk);
            placements.check_result(got);
        end
    end

    initial begin
        int i;
        placements = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default tables: profiles outside the table, then first placements
        // that open bins and fill the gaps left in them.
        send_request(3'd5);
        send_request(3'd6);
        send_request(3'd7);
        send_request(3'd4);
        send_request(3'd0);
        send_request(3'd0);
        send_request(3'd3);
        send_request(3'd2);
        send_request(3'd1);
        settle();

        // Tiny fresh bins: oversized demand has no room, profile 3 needs nothing.
        set_config(32'h000F_0311, 32'h000F_0421, 32'd1, 32'd1);
        send_request(3'd4);
        send_request(3'd3);
        send_request(3'd3);
        send_request(3'd2);
        send_request(3'd1);
        send_request(3'd0);
        send_request(3'd0);
        settle();

        set_config(draw_demand_table(), draw_demand_table(), 32'd15, 32'd15);
        send_random(100);
        settle();

        set_config(draw_demand_table(), draw_demand_table(), 32'd1, 32'd1);
        send_random(100);
        settle();

        // Every in-table request needs a whole fresh bin, so requests are refused once all bins are open.
        set_config(32'h000F_FFFF, 32'h000F_FFFF, 32'd15, 32'd15);
        send_random(20);
        settle();

        // Zero demand everywhere: every in-table request lands in bin 0 and counts saturate.
        set_config(32'd0, 32'd0, 32'($urandom_range(1, 15)), 32'($urandom_range(1, 15)));
        for (i = 0; i < 20; i++) begin
            send_request(3'd0);
        end
        send_random(60);
        settle();

        set_config(draw_demand_table(), draw_demand_table(), 32'($urandom_range(1, 15)),
                   32'($urandom_range(1, 15)));
        send_random(100);
        settle();

        steady_flow = 1'b1;
        set_config(draw_demand_table(), draw_demand_table(), 32'($urandom_range(1, 15)),
                   32'($urandom_range(1, 15)));
        send_random(100);
        settle();
        steady_flow = 1'b0;

        set_config($urandom, $urandom, 32'($urandom_range(1, 15)), 32'($urandom_range(1, 15)));
        send_random(100);
        settle();

        repeat (30) @(posedge i_clk);
        if (placements.errors == 0 && placements.awaited.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
